// File: rtl/hsv_to_rgb_converter_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Implication checked at every rising edge once reset is released.
`define HSVRGB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hsv_to_rgb check failed");

// Condition that must never hold once reset is released.
`define HSVRGB_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(expr)) else $error("hsv_to_rgb check failed");

`endif

// File: rtl/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int CHAN_W = 8;

    // V*S product and its numerators over the common denominator 600000
    localparam int PRD_W = 2 * PCT_W;
    localparam int NUM_W = 20;
    localparam int K_W   = 6;

    // floor(255*N/600000) = floor(floor(17*N/64) / 625)
    localparam int SCL_W       = 18;
    localparam int PRE_SHIFT   = 6;
    localparam int DIV_Q       = 625;
    localparam int RECIP       = 53687;
    localparam int RECIP_SHIFT = 25;
    localparam int PROD_W      = 34;

    // input register, two multiply stages, three scaling stages
    localparam int LATENCY = 6;

    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

    typedef enum logic [2:0] {
        SEC_0    = 3'd0,
        SEC_1    = 3'd1,
        SEC_2    = 3'd2,
        SEC_3    = 3'd3,
        SEC_4    = 3'd4,
        SEC_5    = 3'd5,
        SEC_NONE = 3'd6
    } t_sector;

endpackage

`default_nettype wire

// File: rtl/hsvrgb_scale.sv
`default_nettype none

// One channel: sum offset and part, scale by 255 and divide by 600000, floored.
module hsvrgb_scale (
    input  wire logic                           i_clk,
    input  wire logic [hsvrgb_pkg::NUM_W-1:0]   i_num_m,
    input  wire logic [hsvrgb_pkg::NUM_W-1:0]   i_num_p,
    output logic      [hsvrgb_pkg::CHAN_W-1:0]  o_chan
);

    localparam int SUM_W = hsvrgb_pkg::NUM_W + 1;
    localparam int M17_W = SUM_W + 5;
    localparam int Q0_W  = hsvrgb_pkg::CHAN_W + 1;

    logic [SUM_W-1:0]                  sum;
    logic [M17_W-1:0]                  mul17;
    logic [hsvrgb_pkg::SCL_W-1:0]      n_x;
    logic [hsvrgb_pkg::SCL_W-1:0]      r_x;
    logic [hsvrgb_pkg::SCL_W-1:0]      r_x_d;
    logic [hsvrgb_pkg::PROD_W-1:0]     r_prod;
    logic [Q0_W-1:0]                   q0;
    logic [hsvrgb_pkg::SCL_W-1:0]      rem;
    logic [Q0_W-1:0]                   q;
    logic [hsvrgb_pkg::CHAN_W-1:0]     r_chan;

    always_comb begin
        sum   = {1'b0, i_num_m} + {1'b0, i_num_p};
        mul17 = (M17_W'(sum) << 4) + M17_W'(sum);
        n_x   = mul17[hsvrgb_pkg::SCL_W + hsvrgb_pkg::PRE_SHIFT - 1 : hsvrgb_pkg::PRE_SHIFT];
    end

    // reciprocal estimate is low by at most one; fix it with one compare
    always_comb begin
        q0  = r_prod[hsvrgb_pkg::RECIP_SHIFT + Q0_W - 1 : hsvrgb_pkg::RECIP_SHIFT];
        rem = r_x_d - (hsvrgb_pkg::SCL_W'(q0) * hsvrgb_pkg::SCL_W'(hsvrgb_pkg::DIV_Q));
        q   = (rem >= hsvrgb_pkg::SCL_W'(hsvrgb_pkg::DIV_Q)) ? q0 + Q0_W'(1) : q0;
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_x_d  <= r_x;
        r_prod <= hsvrgb_pkg::PROD_W'(r_x) * hsvrgb_pkg::PROD_W'(hsvrgb_pkg::RECIP);
        r_chan <= q[hsvrgb_pkg::CHAN_W-1:0];
    end

    assign o_chan = r_chan;

endmodule

`default_nettype wire

// File: rtl/hsv_to_rgb_converter_unit.sv
// HSV to RGB pixel converter. A pixel (hue 0..359 degrees, saturation and
// value 0..100 percent; larger saturation or value counts as 100) is taken
// at every edge where start is high, one pixel per clock with no gaps
// needed. busy is always low. The 8-bit red, green and blue appear at the
// end of the pipeline for exactly one cycle, marked by o_done; the receiver
// cannot hold them off, so they must be captured on that cycle. The pipeline
// is input clamp and sector decode, two multiply stages, and three stages of
// the exact scale-by-255/600000 per channel. A hue of 360 or more gives all
// three channels equal to the offset (gray).
`default_nettype none

module hsv_to_rgb_converter_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [hsvrgb_pkg::HUE_W-1:0]      i_hue_deg,
    input  wire logic [hsvrgb_pkg::PCT_W-1:0]      i_sat_pct,
    input  wire logic [hsvrgb_pkg::PCT_W-1:0]      i_val_pct,
    output logic                                   o_done,
    output logic      [hsvrgb_pkg::CHAN_W-1:0]     o_red_out,
    output logic      [hsvrgb_pkg::CHAN_W-1:0]     o_green_out,
    output logic      [hsvrgb_pkg::CHAN_W-1:0]     o_blue_out
);

    localparam int HW = hsvrgb_pkg::HUE_W;
    localparam int PW = hsvrgb_pkg::PCT_W;
    localparam int NW = hsvrgb_pkg::NUM_W;

    logic [hsvrgb_pkg::LATENCY-1:0]    r_vld;
    logic [hsvrgb_pkg::LATENCY-1:0]    n_vld;

    // stage 1
    logic [PW-1:0]                     n_s;
    logic [PW-1:0]                     n_v;
    logic [HW-1:0]                     r120;
    logic [HW-1:0]                     hue_dist;
    logic [HW-1:0]                     k_full;
    hsvrgb_pkg::t_sector               n_sec;
    logic [PW-1:0]                     r_s1_s;
    logic [PW-1:0]                     r_s1_v;
    logic [hsvrgb_pkg::K_W-1:0]        r_s1_k;
    hsvrgb_pkg::t_sector               r_s1_sec;

    // stage 2
    logic [hsvrgb_pkg::PRD_W-1:0]      r_s2_vs;
    logic [hsvrgb_pkg::PRD_W-1:0]      r_s2_vm;
    logic [hsvrgb_pkg::K_W-1:0]        r_s2_k;
    hsvrgb_pkg::t_sector               r_s2_sec;

    // stage 3
    logic [NW-1:0]                     r_s3_cn;
    logic [NW-1:0]                     r_s3_xn;
    logic [NW-1:0]                     r_s3_mn;
    hsvrgb_pkg::t_sector               r_s3_sec;

    logic [NW-1:0]                     pr;
    logic [NW-1:0]                     pg;
    logic [NW-1:0]                     pb;

    always_comb begin
        n_s = (i_sat_pct > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : i_sat_pct;
        n_v = (i_val_pct > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : i_val_pct;

        priority if (i_hue_deg < HW'(60))  n_sec = hsvrgb_pkg::SEC_0;
        else if (i_hue_deg < HW'(120))     n_sec = hsvrgb_pkg::SEC_1;
        else if (i_hue_deg < HW'(180))     n_sec = hsvrgb_pkg::SEC_2;
        else if (i_hue_deg < HW'(240))     n_sec = hsvrgb_pkg::SEC_3;
        else if (i_hue_deg < HW'(300))     n_sec = hsvrgb_pkg::SEC_4;
        else if (i_hue_deg < HW'(360))     n_sec = hsvrgb_pkg::SEC_5;
        else                               n_sec = hsvrgb_pkg::SEC_NONE;

        // hue mod 120; for the out-of-range hue the weight is unused
        priority if (i_hue_deg >= HW'(240)) r120 = i_hue_deg - HW'(240);
        else if (i_hue_deg >= HW'(120))     r120 = i_hue_deg - HW'(120);
        else                                r120 = i_hue_deg;

        hue_dist = (r120 >= HW'(60)) ? (r120 - HW'(60)) : (HW'(60) - r120);
        k_full   = HW'(60) - hue_dist;
    end

    always_ff @(posedge i_clk) begin
        r_s1_s   <= n_s;
        r_s1_v   <= n_v;
        r_s1_k   <= k_full[hsvrgb_pkg::K_W-1:0];
        r_s1_sec <= n_sec;

        r_s2_vs  <= hsvrgb_pkg::PRD_W'(r_s1_v) * hsvrgb_pkg::PRD_W'(r_s1_s);
        r_s2_vm  <= hsvrgb_pkg::PRD_W'(r_s1_v) * hsvrgb_pkg::PRD_W'(hsvrgb_pkg::PCT_MAX - r_s1_s);
        r_s2_k   <= r_s1_k;
        r_s2_sec <= r_s1_sec;

        r_s3_cn  <= NW'(r_s2_vs) * NW'(60);
        r_s3_xn  <= NW'(r_s2_vs) * NW'(r_s2_k);
        r_s3_mn  <= NW'(r_s2_vm) * NW'(60);
        r_s3_sec <= r_s2_sec;
    end

    always_comb begin
        pr = '0;
        pg = '0;
        pb = '0;
        unique case (r_s3_sec)
            hsvrgb_pkg::SEC_0: begin
                pr = r_s3_cn;
                pg = r_s3_xn;
            end
            hsvrgb_pkg::SEC_1: begin
                pr = r_s3_xn;
                pg = r_s3_cn;
            end
            hsvrgb_pkg::SEC_2: begin
                pg = r_s3_cn;
                pb = r_s3_xn;
            end
            hsvrgb_pkg::SEC_3: begin
                pg = r_s3_xn;
                pb = r_s3_cn;
            end
            hsvrgb_pkg::SEC_4: begin
                pr = r_s3_xn;
                pb = r_s3_cn;
            end
            hsvrgb_pkg::SEC_5: begin
                pr = r_s3_cn;
                pb = r_s3_xn;
            end
            default: begin
                // no sector: every channel is the offset alone
                pr = '0;
            end
        endcase
    end

    hsvrgb_scale u_scale_r (
        .i_clk   (i_clk),
        .i_num_m (r_s3_mn),
        .i_num_p (pr),
        .o_chan  (o_red_out)
    );

    hsvrgb_scale u_scale_g (
        .i_clk   (i_clk),
        .i_num_m (r_s3_mn),
        .i_num_p (pg),
        .o_chan  (o_green_out)
    );

    hsvrgb_scale u_scale_b (
        .i_clk   (i_clk),
        .i_num_m (r_s3_mn),
        .i_num_p (pb),
        .o_chan  (o_blue_out)
    );

    // advance the beat markers alongside the data
    always_comb begin
        n_vld = {r_vld[hsvrgb_pkg::LATENCY-2:0], start};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign busy   = 1'b0;
    assign o_done = r_vld[hsvrgb_pkg::LATENCY-1];

endmodule

`default_nettype wire

// File: rtl/hsvrgb_checker.sv
`default_nettype none

`include "hsv_to_rgb_converter_unit_macros.svh"

module hsvrgb_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic [hsvrgb_pkg::HUE_W-1:0]      i_hue_deg,
    input  wire logic [hsvrgb_pkg::PCT_W-1:0]      i_val_pct,
    input  wire logic                              o_done,
    input  wire logic [hsvrgb_pkg::CHAN_W-1:0]     o_red_out,
    input  wire logic [hsvrgb_pkg::CHAN_W-1:0]     o_green_out,
    input  wire logic [hsvrgb_pkg::CHAN_W-1:0]     o_blue_out
);

    logic hue_past_range;
    logic val_zero;
    logic rgb_gray;
    logic rgb_black;

    assign hue_past_range = (i_hue_deg >= 9'd360);
    assign val_zero       = (i_val_pct == 7'd0);
    assign rgb_gray       = (o_red_out == o_green_out) && (o_green_out == o_blue_out);
    assign rgb_black      = (o_red_out == 8'd0) && (o_green_out == 8'd0) && (o_blue_out == 8'd0);

    // every accepted beat comes out after the fixed latency
    `HSVRGB_ASSERT_IMPL(a_beat_out, start && !busy, ##(hsvrgb_pkg::LATENCY) o_done)

    // no result without a beat taken the latency earlier
    `HSVRGB_ASSERT_NEVER(a_no_spurious, o_done && !$past(start && !busy, hsvrgb_pkg::LATENCY))

    // out-of-range hue gives gray
    `HSVRGB_ASSERT_IMPL(a_hue_gray, o_done && $past(hue_past_range, hsvrgb_pkg::LATENCY), rgb_gray)

    // zero value gives black
    `HSVRGB_ASSERT_IMPL(a_black, o_done && $past(val_zero, hsvrgb_pkg::LATENCY), rgb_black)

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_hsvrgb_checker (.*);

`default_nettype wire
